>>> src/audio_route_command_decoder_assert.svh
// ----------------------------------------------------------------------------
// audio_route_command_decoder_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef AUDIO_ROUTE_COMMAND_DECODER_ASSERT_SVH
`define AUDIO_ROUTE_COMMAND_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ACRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("acrd assertion failed");

// antecedent implies consequent in the next cycle
`define ACRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("acrd assertion failed");

`endif

>>> src/acrd_pkg.sv
// ----------------------------------------------------------------------------
// acrd_pkg
// types and constants of the audio route command decoder
// ----------------------------------------------------------------------------
package acrd_pkg;

	// item kinds on the input channel
	typedef enum logic [1:0] {
		OP_CMD  = 2'd0,
		OP_LINE = 2'd1,
		OP_IDLE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// classified actions passed from front to back
	typedef enum logic [3:0] {
		K_NOP,
		K_GAIN_SET,
		K_GAIN_DN,
		K_GAIN_UP,
		K_TX_MUTE,
		K_RX_MUTE,
		K_SIDETONE,
		K_CALL,
		K_LINE,
		K_IDLE
	} kind_t;

	// command byte codes
	localparam logic [7:0] CMD_GAIN_0    = 8'h20;
	localparam logic [7:0] CMD_GAIN_3    = 8'h23;
	localparam logic [7:0] CMD_GAIN_DN   = 8'h24;
	localparam logic [7:0] CMD_GAIN_UP   = 8'h25;
	localparam logic [7:0] CMD_TX_UNMUTE = 8'h26;
	localparam logic [7:0] CMD_TX_MUTE   = 8'h27;
	localparam logic [7:0] CMD_RX_UNMUTE = 8'h28;
	localparam logic [7:0] CMD_RX_MUTE   = 8'h29;
	localparam logic [7:0] CMD_ST_ON     = 8'h2a;
	localparam logic [7:0] CMD_ST_OFF    = 8'h2b;
	localparam logic [7:0] CMD_TONE_A    = 8'h2d;
	localparam logic [7:0] CMD_TONE_B    = 8'h2e;
	localparam logic [7:0] CMD_TONE_C    = 8'h2f;
	localparam logic [7:0] CMD_CALL_0    = 8'h40;
	localparam logic [7:0] CMD_CALL_6    = 8'h46;

	// call states
	localparam logic [2:0] CS_IDLE     = 3'd0;
	localparam logic [2:0] CS_DIALING  = 3'd1;
	localparam logic [2:0] CALL_EST_LO = 3'd2;
	localparam logic [2:0] CALL_EST_HI = 3'd6;

	// route codes
	localparam logic [1:0] ROUTE_IDLE    = 2'd0;
	localparam logic [1:0] ROUTE_DIALING = 2'd1;
	localparam logic [1:0] ROUTE_CALL    = 2'd2;
	localparam logic [1:0] ROUTE_PROMPT  = 2'd3;

	// line status codes
	localparam logic [2:0] LS_ON_HOOK  = 3'd0;
	localparam logic [2:0] LS_OFF_HOOK = 3'd1;
	localparam logic [2:0] LS_DIALING  = 3'd2;
	localparam logic [2:0] LS_CONNECT  = 3'd3;
	localparam logic [2:0] LS_DISCONN  = 3'd4;
	localparam logic [2:0] LS_PROMPT   = 3'd5;

	// widest gain step the register holds
	localparam logic [1:0] GAIN_MAX = 2'd3;

	// one queue entry: arg is gain, call state, flag or {hook, prompt, carrier}
	typedef struct packed {
		kind_t      kind;
		logic [2:0] arg;
		logic       recognized;
		logic       note;
	} cmd_t;

endpackage

>>> src/acrd_in_if.sv
// ----------------------------------------------------------------------------
// acrd_in_if
// input channel: item kind, command byte and line status flags
// ----------------------------------------------------------------------------
interface acrd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] cmd_byte;
	logic       hook_off_in;
	logic       prompt_path_in;
	logic       carrier_up_in;

	modport source (
		output valid, opcode, cmd_byte, hook_off_in, prompt_path_in, carrier_up_in,
		input  ready
	);
	modport sink (
		input  valid, opcode, cmd_byte, hook_off_in, prompt_path_in, carrier_up_in,
		output ready
	);
endinterface

>>> src/acrd_out_if.sv
// ----------------------------------------------------------------------------
// acrd_out_if
// result channel: state report after each word
// ----------------------------------------------------------------------------
interface acrd_out_if;
	logic       valid;
	logic       ready;
	logic       recognized;
	logic       note_code;
	logic [2:0] call_code;
	logic       mic_muted;
	logic       earpiece_muted;
	logic       sidetone_off;
	logic [1:0] gain_level;
	logic [1:0] route_code;
	logic [2:0] line_status_code;

	modport source (
		output valid, recognized, note_code, call_code, mic_muted, earpiece_muted,
		       sidetone_off, gain_level, route_code, line_status_code,
		input  ready
	);
	modport sink (
		input  valid, recognized, note_code, call_code, mic_muted, earpiece_muted,
		       sidetone_off, gain_level, route_code, line_status_code,
		output ready
	);
endinterface

>>> src/acrd_front.sv
// ----------------------------------------------------------------------------
// acrd_front
// classifies an incoming word into an action for the back end
// ----------------------------------------------------------------------------
module acrd_front (
	input  logic [1:0]    opcode,
	input  logic [7:0]    cmd_byte,
	input  logic          hook_off_in,
	input  logic          prompt_path_in,
	input  logic          carrier_up_in,
	output acrd_pkg::cmd_t cmd
);

	acrd_pkg::op_t op;

	assign op = acrd_pkg::op_t'(opcode);

	// byte and opcode decode
	always_comb begin
		cmd.kind       = acrd_pkg::K_NOP;
		cmd.arg        = 3'd0;
		cmd.recognized = 1'b0;
		cmd.note       = 1'b0;
		case (op)
			acrd_pkg::OP_CMD: begin
				if (cmd_byte >= acrd_pkg::CMD_GAIN_0 && cmd_byte <= acrd_pkg::CMD_GAIN_3) begin
					cmd.kind       = acrd_pkg::K_GAIN_SET;
					cmd.arg        = {1'b0, cmd_byte[1:0]};
					cmd.recognized = 1'b1;
					cmd.note       = (cmd_byte != acrd_pkg::CMD_GAIN_0);
				end else if (cmd_byte >= acrd_pkg::CMD_CALL_0 &&
				             cmd_byte <= acrd_pkg::CMD_CALL_6) begin
					cmd.kind       = acrd_pkg::K_CALL;
					cmd.arg        = cmd_byte[2:0];
					cmd.recognized = 1'b1;
				end else begin
					case (cmd_byte)
						acrd_pkg::CMD_GAIN_DN: begin
							cmd.kind       = acrd_pkg::K_GAIN_DN;
							cmd.recognized = 1'b1;
						end
						acrd_pkg::CMD_GAIN_UP: begin
							cmd.kind       = acrd_pkg::K_GAIN_UP;
							cmd.recognized = 1'b1;
						end
						acrd_pkg::CMD_TX_UNMUTE, acrd_pkg::CMD_TX_MUTE: begin
							cmd.kind       = acrd_pkg::K_TX_MUTE;
							cmd.arg        = {2'b00, cmd_byte[0]};
							cmd.recognized = 1'b1;
						end
						acrd_pkg::CMD_RX_UNMUTE, acrd_pkg::CMD_RX_MUTE: begin
							cmd.kind       = acrd_pkg::K_RX_MUTE;
							cmd.arg        = {2'b00, cmd_byte[0]};
							cmd.recognized = 1'b1;
						end
						acrd_pkg::CMD_ST_ON, acrd_pkg::CMD_ST_OFF: begin
							cmd.kind       = acrd_pkg::K_SIDETONE;
							cmd.arg        = {2'b00, cmd_byte[0]};
							cmd.recognized = 1'b1;
						end
						// tone and dtmf bytes: acknowledged only
						acrd_pkg::CMD_TONE_A, acrd_pkg::CMD_TONE_B, acrd_pkg::CMD_TONE_C: begin
							cmd.recognized = 1'b1;
						end
						default: begin
							cmd.recognized = 1'b0;
						end
					endcase
				end
			end
			acrd_pkg::OP_LINE: begin
				cmd.kind = acrd_pkg::K_LINE;
				cmd.arg  = {hook_off_in, prompt_path_in, carrier_up_in};
			end
			acrd_pkg::OP_IDLE: begin
				cmd.kind = acrd_pkg::K_IDLE;
			end
			default: begin
				cmd.kind = acrd_pkg::K_NOP;
			end
		endcase
	end

endmodule

>>> src/acrd_queue.sv
// ----------------------------------------------------------------------------
// acrd_queue
// two-entry queue decoupling the classifier from the state update
// ----------------------------------------------------------------------------
module acrd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  acrd_pkg::cmd_t push_data,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output acrd_pkg::cmd_t pop_data
);

	acrd_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> src/acrd_back.sv
// ----------------------------------------------------------------------------
// acrd_back
// applies queued actions to the call state and registers the report
// ----------------------------------------------------------------------------
module acrd_back #(
	parameter logic [1:0] GainCeil = 2'd3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  acrd_pkg::cmd_t q_data,
	output logic           q_pop,
	acrd_out_if.source     rsp
);

	logic [2:0] call_q;
	logic       tx_mute_q;
	logic       rx_mute_q;
	logic       sidetone_q;
	logic       hook_q;
	logic       prompt_q;
	logic       carrier_q;
	logic [1:0] gain_q;
	logic       out_valid_q;

	logic [2:0] call_d;
	logic       tx_mute_d;
	logic       rx_mute_d;
	logic       sidetone_d;
	logic       hook_d;
	logic       prompt_d;
	logic       carrier_d;
	logic [1:0] gain_d;
	logic       est_d;
	logic [1:0] route_d;
	logic [2:0] line_d;

	logic       recog_q;
	logic       note_q;
	logic [1:0] route_q;
	logic [2:0] line_q;

	// take the next word whenever the report register is free or draining
	assign q_pop = q_valid && (!out_valid_q || rsp.ready);

	// next state
	always_comb begin
		call_d     = call_q;
		tx_mute_d  = tx_mute_q;
		rx_mute_d  = rx_mute_q;
		sidetone_d = sidetone_q;
		hook_d     = hook_q;
		prompt_d   = prompt_q;
		carrier_d  = carrier_q;
		gain_d     = gain_q;
		case (q_data.kind)
			acrd_pkg::K_GAIN_SET: gain_d = q_data.arg[1:0];
			acrd_pkg::K_GAIN_DN: begin
				if (gain_q != 2'd0) gain_d = gain_q - 2'd1;
			end
			acrd_pkg::K_GAIN_UP: begin
				if (gain_q < GainCeil) gain_d = gain_q + 2'd1;
			end
			acrd_pkg::K_TX_MUTE:  tx_mute_d  = q_data.arg[0];
			acrd_pkg::K_RX_MUTE:  rx_mute_d  = q_data.arg[0];
			acrd_pkg::K_SIDETONE: sidetone_d = q_data.arg[0];
			acrd_pkg::K_CALL:     call_d     = q_data.arg;
			acrd_pkg::K_LINE: begin
				hook_d    = q_data.arg[2];
				prompt_d  = q_data.arg[1];
				carrier_d = q_data.arg[0];
			end
			acrd_pkg::K_IDLE: begin
				call_d     = acrd_pkg::CS_IDLE;
				tx_mute_d  = 1'b0;
				rx_mute_d  = 1'b0;
				sidetone_d = 1'b0;
				hook_d     = 1'b0;
				prompt_d   = 1'b0;
				carrier_d  = 1'b0;
				gain_d     = 2'd0;
			end
			default: begin
				call_d = call_q;
			end
		endcase
	end

	// route and line status from the updated state
	always_comb begin
		est_d = (call_d >= acrd_pkg::CALL_EST_LO) && (call_d <= acrd_pkg::CALL_EST_HI);

		if (hook_d && prompt_d)                 route_d = acrd_pkg::ROUTE_PROMPT;
		else if (call_d == acrd_pkg::CS_DIALING) route_d = acrd_pkg::ROUTE_DIALING;
		else if (est_d)                         route_d = acrd_pkg::ROUTE_CALL;
		else                                    route_d = acrd_pkg::ROUTE_IDLE;

		if (prompt_d)                            line_d = acrd_pkg::LS_PROMPT;
		else if (call_d == acrd_pkg::CS_DIALING) line_d = acrd_pkg::LS_DIALING;
		else if (est_d)  line_d = carrier_d ? acrd_pkg::LS_CONNECT : acrd_pkg::LS_DISCONN;
		else if (hook_d)                         line_d = acrd_pkg::LS_OFF_HOOK;
		else                                     line_d = acrd_pkg::LS_ON_HOOK;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_q     <= acrd_pkg::CS_IDLE;
			tx_mute_q  <= 1'b0;
			rx_mute_q  <= 1'b0;
			sidetone_q <= 1'b0;
			hook_q     <= 1'b0;
			prompt_q   <= 1'b0;
			carrier_q  <= 1'b0;
			gain_q     <= 2'd0;
		end else if (q_pop) begin
			call_q     <= call_d;
			tx_mute_q  <= tx_mute_d;
			rx_mute_q  <= rx_mute_d;
			sidetone_q <= sidetone_d;
			hook_q     <= hook_d;
			prompt_q   <= prompt_d;
			carrier_q  <= carrier_d;
			gain_q     <= gain_d;
		end
	end

	// report valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// report payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			recog_q <= q_data.recognized;
			note_q  <= q_data.note;
			route_q <= route_d;
			line_q  <= line_d;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.recognized       = recog_q;
	assign rsp.note_code        = note_q;
	assign rsp.call_code        = call_q;
	assign rsp.mic_muted        = tx_mute_q;
	assign rsp.earpiece_muted   = rx_mute_q;
	assign rsp.sidetone_off     = sidetone_q;
	assign rsp.gain_level       = gain_q;
	assign rsp.route_code       = route_q;
	assign rsp.line_status_code = line_q;

endmodule

>>> src/audio_route_command_decoder.sv
// an accepted word passes through the queue and the report register before its report is offered
// throughput: one word per cycle, sustained while the report side keeps ready high
// a two-entry queue between classifier and state update absorbs a stalled report
// reset (arst_n low): call state idle, all flags and gain cleared, queue and report empty
// ----------------------------------------------------------------------------
// audio_route_command_decoder
// audio routing command decoder with call state, mute, sidetone and gain
// ----------------------------------------------------------------------------
module audio_route_command_decoder #(
	parameter int TOP_GAIN_STEP = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	acrd_in_if.sink   cmd,
	acrd_out_if.source rsp
);

	localparam logic [1:0] GainCeil =
		(TOP_GAIN_STEP > int'(acrd_pkg::GAIN_MAX)) ? acrd_pkg::GAIN_MAX : 2'(TOP_GAIN_STEP);

	acrd_pkg::cmd_t front_cmd;
	acrd_pkg::cmd_t head_cmd;
	logic           q_not_full;
	logic           q_not_empty;
	logic           q_pop;
	logic           q_push;

	assign cmd.ready = q_not_full;
	assign q_push    = cmd.valid && q_not_full;

	// classifier
	acrd_front u_front (
		.opcode         (cmd.opcode),
		.cmd_byte       (cmd.cmd_byte),
		.hook_off_in    (cmd.hook_off_in),
		.prompt_path_in (cmd.prompt_path_in),
		.carrier_up_in  (cmd.carrier_up_in),
		.cmd            (front_cmd)
	);

	// decoupling queue
	acrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (head_cmd)
	);

	// state update and report register
	acrd_back #(
		.GainCeil (GainCeil)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_data  (head_cmd),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

>>> src/acrd_checker.sv
// ----------------------------------------------------------------------------
// acrd_checker
// port-level checks on the report channel, bound to the top level
// ----------------------------------------------------------------------------
`include "audio_route_command_decoder_assert.svh"

module acrd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       recognized,
	input logic       note_code,
	input logic [2:0] call_code,
	input logic [1:0] route_code,
	input logic [2:0] line_status_code
);

	// a stalled report stays offered
	`ACRD_ASSERT_NEXT(a_hold_valid, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// gain preset note only comes with a recognised byte
	`ACRD_ASSERT_NOW(a_note_recog, clk, arst_n, rsp_valid && note_code, recognized)

	// prompt route needs the prompt path, so status shows prompt playback
	`ACRD_ASSERT_NOW(a_route_prompt, clk, arst_n, rsp_valid && route_code == acrd_pkg::ROUTE_PROMPT, line_status_code == acrd_pkg::LS_PROMPT)

	// dialing route and dialing status agree unless the prompt path overrides
	`ACRD_ASSERT_NOW(a_dial_status, clk, arst_n, rsp_valid && route_code == acrd_pkg::ROUTE_DIALING, call_code == acrd_pkg::CS_DIALING && (line_status_code == acrd_pkg::LS_DIALING || line_status_code == acrd_pkg::LS_PROMPT))

endmodule

bind audio_route_command_decoder acrd_checker u_acrd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.recognized       (rsp.recognized),
	.note_code        (rsp.note_code),
	.call_code        (rsp.call_code),
	.route_code       (rsp.route_code),
	.line_status_code (rsp.line_status_code)
);

>>> verif/audio_route_command_decoder_test.sv
// ----------------------------------------------------------------------------
// audio_route_command_decoder_test
// self-checking bench for the audio route command decoder: a directed table
// of command, line, idle and unused-opcode words, then weighted random
// words, with every report checked field by field against a local model of
// the call state
module audio_route_command_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import acrd_pkg::*;

	localparam int GAIN_STEP_TOP = 3;
	localparam int N_RANDOM      = 800;
	localparam int LONG_HOLD     = 80;

	// one input word and one report
	typedef struct packed {
		op_t        op;
		logic [7:0] code;
		logic       hook;
		logic       prompt;
		logic       carrier;
	} word_t;

	typedef struct packed {
		logic       recog;
		logic       note;
		logic [2:0] call;
		logic       mic;
		logic       ear;
		logic       side;
		logic [1:0] gain;
		logic [1:0] route;
		logic [2:0] status;
	} report_t;

	typedef struct {
		word_t   w;
		bit      typed;
		report_t r;
	} plan_row_t;

	localparam report_t CLEAR_REPORT = '0;

	logic clk;
	logic arst_n;

	acrd_in_if  cmd_ch ();
	acrd_out_if rsp_ch ();

	audio_route_command_decoder #(
		.TOP_GAIN_STEP(GAIN_STEP_TOP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// local copy of the call state
	logic [2:0] call_st;
	logic       tx_mute_st;
	logic       rx_mute_st;
	logic       sidetone_st;
	logic       hook_st;
	logic       prompt_st;
	logic       carrier_st;
	logic [1:0] gain_st;

	report_t expected_reports[$];

	int  errors;
	int  n_checked;
	int  n_cmd;
	int  n_recog;
	int  n_line;
	int  n_idle;
	int  n_none;
	int  in_stall_cycles;
	int  hold_ticket;
	bit  src_gaps;
	bit  sink_gaps;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// safety net
	initial begin
		#5_000_000;
		$display("%0t timeout with %0d reports outstanding", $time, expected_reports.size());
		$display("FAIL");
		$finish;
	end

	function automatic word_t mk_word(op_t op, logic [7:0] code, logic [2:0] flags);
		word_t w;
		w.op      = op;
		w.code    = code;
		w.hook    = flags[2];
		w.prompt  = flags[1];
		w.carrier = flags[0];
		return w;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void clear_call_state();
		call_st     = CS_IDLE;
		tx_mute_st  = 1'b0;
		rx_mute_st  = 1'b0;
		sidetone_st = 1'b0;
		hook_st     = 1'b0;
		prompt_st   = 1'b0;
		carrier_st  = 1'b0;
		gain_st     = '0;
	endfunction

	// advance the local state by one word and form its report
	function automatic report_t apply_word(word_t w);
		report_t    r;
		logic [1:0] ceiling;
		bit         established;
		r       = CLEAR_REPORT;
		ceiling = (GAIN_STEP_TOP > GAIN_MAX) ? GAIN_MAX : 2'(GAIN_STEP_TOP);
		case (w.op)
			OP_CMD: begin
				r.recog = 1'b1;
				if (w.code >= CMD_GAIN_0 && w.code <= CMD_GAIN_3) begin
					gain_st = 2'(w.code - CMD_GAIN_0);
					r.note  = (w.code != CMD_GAIN_0);
				end else if (w.code >= CMD_CALL_0 && w.code <= CMD_CALL_6) begin
					call_st = 3'(w.code - CMD_CALL_0);
				end else begin
					case (w.code)
						CMD_GAIN_DN:   if (gain_st != '0) gain_st = gain_st - 2'd1;
						CMD_GAIN_UP:   if (gain_st < ceiling) gain_st = gain_st + 2'd1;
						CMD_TX_UNMUTE: tx_mute_st = 1'b0;
						CMD_TX_MUTE:   tx_mute_st = 1'b1;
						CMD_RX_UNMUTE: rx_mute_st = 1'b0;
						CMD_RX_MUTE:   rx_mute_st = 1'b1;
						CMD_ST_ON:     sidetone_st = 1'b0;
						CMD_ST_OFF:    sidetone_st = 1'b1;
						CMD_TONE_A, CMD_TONE_B, CMD_TONE_C: ;
						default:       r.recog = 1'b0;
					endcase
				end
			end
			OP_LINE: begin
				hook_st    = w.hook;
				prompt_st  = w.prompt;
				carrier_st = w.carrier;
			end
			OP_IDLE: clear_call_state();
			default: ;
		endcase

		established = (call_st >= CALL_EST_LO && call_st <= CALL_EST_HI);
		r.call = call_st;
		r.mic  = tx_mute_st;
		r.ear  = rx_mute_st;
		r.side = sidetone_st;
		r.gain = gain_st;

		// route: prompt with handset up wins, else follows the call
		if (hook_st && prompt_st)       r.route = ROUTE_PROMPT;
		else if (call_st == CS_DIALING) r.route = ROUTE_DIALING;
		else if (established)           r.route = ROUTE_CALL;
		else                            r.route = ROUTE_IDLE;

		// line status: prompt, dialing, call by carrier, then hook
		if (prompt_st)                  r.status = LS_PROMPT;
		else if (call_st == CS_DIALING) r.status = LS_DIALING;
		else if (established)           r.status = carrier_st ? LS_CONNECT : LS_DISCONN;
		else if (hook_st)               r.status = LS_OFF_HOOK;
		else                            r.status = LS_ON_HOOK;
		return r;
	endfunction

	// offer one word, wait for it to be taken, record what it should report
	task automatic send_word(word_t w, bit typed, report_t typed_r);
		report_t r;
		cmd_ch.valid          <= 1'b1;
		cmd_ch.opcode         <= w.op;
		cmd_ch.cmd_byte       <= w.code;
		cmd_ch.hook_off_in    <= w.hook;
		cmd_ch.prompt_path_in <= w.prompt;
		cmd_ch.carrier_up_in  <= w.carrier;
		do @(posedge clk); while (!cmd_ch.ready);
		r = apply_word(w);
		expected_reports.push_back(typed ? typed_r : r);
		case (w.op)
			OP_CMD: begin
				n_cmd++;
				if (r.recog) n_recog++;
			end
			OP_LINE: n_line++;
			OP_IDLE: n_idle++;
			default: n_none++;
		endcase
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
	endtask

	// report side: random stalls plus one long hold-off on request
	initial begin : report_sink
		int stall_left;
		int hold_seen;
		stall_left   = 0;
		hold_seen    = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_ticket != hold_seen) begin
				hold_seen  = hold_ticket;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
				stall_left   = gap_len() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t error: %s expected %0d got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// report checker
	always @(posedge clk) begin
		report_t want;
		if (arst_n && cmd_ch.valid && !cmd_ch.ready) in_stall_cycles++;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t error: report with no word pending", $time);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				n_checked++;
				compare_field("recognized", 32'(want.recog), 32'(rsp_ch.recognized));
				compare_field("note_code", 32'(want.note), 32'(rsp_ch.note_code));
				compare_field("call_code", 32'(want.call), 32'(rsp_ch.call_code));
				compare_field("mic_muted", 32'(want.mic), 32'(rsp_ch.mic_muted));
				compare_field("earpiece_muted", 32'(want.ear), 32'(rsp_ch.earpiece_muted));
				compare_field("sidetone_off", 32'(want.side), 32'(rsp_ch.sidetone_off));
				compare_field("gain_level", 32'(want.gain), 32'(rsp_ch.gain_level));
				compare_field("route_code", 32'(want.route), 32'(rsp_ch.route_code));
				compare_field("line_status_code", 32'(want.status),
					32'(rsp_ch.line_status_code));
			end
		end
	end

	// stimulus
	initial begin
		plan_row_t  plan[$];
		logic [7:0] known_cmds[$];
		word_t      w;
		int         pick;
		int         n_rand;
		bit         held;
		bit         paused;

		errors          = 0;
		n_checked       = 0;
		n_cmd           = 0;
		n_recog         = 0;
		n_line          = 0;
		n_idle          = 0;
		n_none          = 0;
		in_stall_cycles = 0;
		hold_ticket     = 0;
		src_gaps        = 1'b1;
		sink_gaps       = 1'b1;
		n_rand          = 0;
		held            = 1'b0;
		paused          = 1'b0;
		clear_call_state();

		cmd_ch.valid          = 1'b0;
		cmd_ch.opcode         = OP_CMD;
		cmd_ch.cmd_byte       = '0;
		cmd_ch.hook_off_in    = 1'b0;
		cmd_ch.prompt_path_in = 1'b0;
		cmd_ch.carrier_up_in  = 1'b0;
		arst_n                = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every byte the decoder knows
		for (int c = CMD_GAIN_0; c <= CMD_CALL_6; c++) begin
			if (c <= CMD_ST_OFF || (c >= CMD_TONE_A && c <= CMD_TONE_C) || c >= CMD_CALL_0)
				known_cmds.push_back(8'(c));
		end

		// directed table: typed reports only where obvious
		// unused opcode and unknown bytes leave the reset state alone
		plan.push_back('{mk_word(OP_NONE, 8'hff, 3'b111), 1'b1, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, 8'h00, 3'b111), 1'b1, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, 8'hff, 3'b000), 1'b1, CLEAR_REPORT});
		// top preset, step up held at the ceiling, bottom preset, step down held at zero
		plan.push_back('{mk_word(OP_CMD, CMD_GAIN_3, 3'b000), 1'b1,
			'{1'b1, 1'b1, CS_IDLE, 1'b0, 1'b0, 1'b0, GAIN_MAX, ROUTE_IDLE, LS_ON_HOOK}});
		plan.push_back('{mk_word(OP_CMD, CMD_GAIN_UP, 3'b000), 1'b1,
			'{1'b1, 1'b0, CS_IDLE, 1'b0, 1'b0, 1'b0, GAIN_MAX, ROUTE_IDLE, LS_ON_HOOK}});
		plan.push_back('{mk_word(OP_CMD, CMD_GAIN_0, 3'b000), 1'b1,
			'{1'b1, 1'b0, CS_IDLE, 1'b0, 1'b0, 1'b0, 2'd0, ROUTE_IDLE, LS_ON_HOOK}});
		plan.push_back('{mk_word(OP_CMD, CMD_GAIN_DN, 3'b000), 1'b1,
			'{1'b1, 1'b0, CS_IDLE, 1'b0, 1'b0, 1'b0, 2'd0, ROUTE_IDLE, LS_ON_HOOK}});
		plan.push_back('{mk_word(OP_CMD, CMD_GAIN_3 - 8'd1, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_TX_MUTE, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_RX_MUTE, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_ST_OFF, 3'b000), 1'b0, CLEAR_REPORT});
		// hole between sidetone and tone bytes
		plan.push_back('{mk_word(OP_CMD, CMD_ST_OFF + 8'd1, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_TONE_A, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_TONE_C, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_CALL_6, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_LINE, 8'h00, 3'b111), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_LINE, 8'hff, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_CALL_0 + 8'd1, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_LINE, 8'h5a, 3'b100), 1'b0, CLEAR_REPORT});
		// bytes just outside the call range
		plan.push_back('{mk_word(OP_CMD, CMD_CALL_6 + 8'd1, 3'b000), 1'b0, CLEAR_REPORT});
		plan.push_back('{mk_word(OP_CMD, CMD_CALL_0 - 8'd1, 3'b000), 1'b0, CLEAR_REPORT});
		// return to idle clears everything, line flags too
		plan.push_back('{mk_word(OP_IDLE, 8'ha5, 3'b111), 1'b1, CLEAR_REPORT});

		foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].r);

		// random words, mostly known commands so the call state moves about
		while (n_rand < N_RANDOM) begin
			if (n_rand == 250) begin
				src_gaps  = 1'b0;
				sink_gaps = 1'b0;
			end
			if (n_rand == 400 && !held) begin
				held        = 1'b1;
				hold_ticket <= hold_ticket + 1;
			end
			if (n_rand == 440 && !paused) begin
				paused = 1'b1;
				wait_drained();
				src_gaps  = 1'b1;
				sink_gaps = 1'b1;
			end
			if (n_rand == 650) src_gaps = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 65)
				w = mk_word(OP_CMD, known_cmds[$urandom_range(0, known_cmds.size() - 1)],
					3'($urandom_range(0, 7)));
			else if (pick < 75)
				w = mk_word(OP_CMD, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
			else if (pick < 93)
				w = mk_word(OP_LINE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
			else if (pick < 96)
				w = mk_word(OP_IDLE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
			else
				w = mk_word(OP_NONE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
			send_word(w, 1'b0, CLEAR_REPORT);
			if (w.op != OP_NONE) n_rand++;
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("run: %0d command words (%0d recognised), %0d line, %0d idle, %0d unused",
			n_cmd, n_recog, n_line, n_idle, n_none);
		$display("run: %0d reports checked, input held off %0d cycles, %0d errors",
			n_checked, in_stall_cycles, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/acrd_pkg.sv
src/acrd_in_if.sv
src/acrd_out_if.sv
src/acrd_front.sv
src/acrd_queue.sv
src/acrd_back.sv
src/audio_route_command_decoder.sv
src/acrd_checker.sv
verif/audio_route_command_decoder_test.sv
